>>> hw/rtl/ckb_pkg.sv
package ckb_pkg;

	localparam int unsigned COORD_W   = 12;   // destination x / y
	localparam int unsigned DIM_W     = 13;   // size registers
	localparam int unsigned OFS_W     = 14;   // signed offsets
	localparam int unsigned PIX_W     = 24;   // r<<16 | g<<8 | b
	localparam int unsigned LIDX_W    = 16;   // load index
	localparam int unsigned DIDX_W    = 24;   // destination index
	localparam int unsigned CFG_W     = 24;   // widest register
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned MAX_DIM   = 4096;
	localparam int unsigned SRC_DEPTH_DEF = 65536;
	localparam int unsigned OUT_DEPTH = 32;   // result queue, must exceed pipe latency

	// mode register bits
	localparam int unsigned MODE_PLACED = 0;
	localparam int unsigned MODE_KEY    = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEST_WIDTH  = 3'd0,
		CFG_DEST_HEIGHT = 3'd1,
		CFG_SRC_WIDTH   = 3'd2,
		CFG_SRC_HEIGHT  = 3'd3,
		CFG_OFFSET_X    = 3'd4,
		CFG_OFFSET_Y    = 3'd5,
		CFG_KEY_COLOR   = 3'd6,
		CFG_MODE        = 3'd7
	} cfg_reg_t;

	// per-item payload that rides along the modulo pipe
	typedef struct packed {
		logic              func;    // 1: query
		logic              li_ok;   // load index inside the store
		logic [LIDX_W-1:0] li;
		logic [PIX_W-1:0]  pix;
		logic              keyed;
	} item_t;

	typedef struct packed {
		logic              we;
		logic [DIDX_W-1:0] didx;
		logic [PIX_W-1:0]  pix;
	} res_t;

endpackage

>>> hw/rtl/ckb_mod_pipe.sv
module ckb_mod_pipe #(
	parameter int unsigned PW = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [ckb_pkg::COORD_W-1:0]  in_x,
	input  logic [ckb_pkg::COORD_W-1:0]  in_y,
	input  logic [PW-1:0]                in_pl,
	input  logic [ckb_pkg::DIM_W-1:0]    div_x,
	input  logic [ckb_pkg::DIM_W-1:0]    div_y,
	output logic                         out_vld,
	output logic [ckb_pkg::COORD_W-1:0]  out_x,
	output logic [ckb_pkg::COORD_W-1:0]  out_y,
	output logic [ckb_pkg::COORD_W-1:0]  out_rx,
	output logic [ckb_pkg::COORD_W-1:0]  out_ry,
	output logic [PW-1:0]                out_pl
);

	localparam int unsigned N = ckb_pkg::COORD_W;

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic logic [N-1:0] mod_step(input logic [N-1:0] rem, input logic b,
	                                          input logic [ckb_pkg::DIM_W-1:0] d);
		logic [N:0] t;
		t = {rem, b};
		return (t >= d) ? N'(t - d) : N'(t);
	endfunction

	logic          vld_s [N];
	logic [N-1:0]  x_s   [N];
	logic [N-1:0]  y_s   [N];
	logic [N-1:0]  rx_s  [N];
	logic [N-1:0]  ry_s  [N];
	logic [PW-1:0] pl_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic          v_i;
		logic [N-1:0]  x_i;
		logic [N-1:0]  y_i;
		logic [N-1:0]  rx_i;
		logic [N-1:0]  ry_i;
		logic [PW-1:0] pl_i;

		if (k == 0) begin : g_first
			assign v_i  = in_vld;
			assign x_i  = in_x;
			assign y_i  = in_y;
			assign rx_i = '0;
			assign ry_i = '0;
			assign pl_i = in_pl;
		end else begin : g_next
			assign v_i  = vld_s[k-1];
			assign x_i  = x_s[k-1];
			assign y_i  = y_s[k-1];
			assign rx_i = rx_s[k-1];
			assign ry_i = ry_s[k-1];
			assign pl_i = pl_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			x_s[k]  <= x_i;
			y_s[k]  <= y_i;
			pl_s[k] <= pl_i;
			rx_s[k] <= mod_step(rx_i, x_i[N-1-k], div_x);
			ry_s[k] <= mod_step(ry_i, y_i[N-1-k], div_y);
		end
	end

	assign out_vld = vld_s[N-1];
	assign out_x   = x_s[N-1];
	assign out_y   = y_s[N-1];
	assign out_rx  = rx_s[N-1];
	assign out_ry  = ry_s[N-1];
	assign out_pl  = pl_s[N-1];

endmodule

>>> hw/rtl/ckb_src_store.sv
module ckb_src_store #(
	parameter int unsigned DEPTH = ckb_pkg::SRC_DEPTH_DEF,
	parameter int unsigned AW    = 16,
	parameter int unsigned DW    = ckb_pkg::PIX_W + 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/ckb_out_fifo.sv
module ckb_out_fifo #(
	parameter int unsigned DEPTH = ckb_pkg::OUT_DEPTH,
	parameter int unsigned W     = $bits(ckb_pkg::res_t)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [W-1:0]                   push_data,
	input  logic                           pop,
	output logic                           out_valid,
	output logic [W-1:0]                   out_data,
	output logic [$clog2(DEPTH+1)-1:0]     level
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)  rd_ptr_q <= nxt(rd_ptr_q);
			case ({push, pop})
				2'b10:   level_q <= LW'(level_q + 1'b1);
				2'b01:   level_q <= LW'(level_q - 1'b1);
				default: level_q <= level_q;
			endcase
		end
	end

	assign out_valid = (level_q != '0);
	assign out_data  = mem[rd_ptr_q];
	assign level     = level_q;

endmodule

>>> hw/rtl/color_key_tile_blitter_unit.sv
// Color-key tile blitter.
// Slave channel s_*: one word per item. s_tuser = func (0 load a source pixel,
// 1 query a destination pixel). Loads write pixel and transparency bit into the
// on-chip source store; queries return write enable, destination index and color.
// Master channel m_*: exactly one result word per accepted input word, in order;
// load words come back with every field zero.
// Config port: cfg_we/cfg_index/cfg_data, one register per cycle, only while idle.
// Path: a word accepted passes through the input register, 12 stages of
// bit-serial modulo (one quotient bit a stage, x and y side by side),
// offset/bounds stage, two multipliers, index add, store read and result
// queue, in that order.
// Throughput: one word per cycle while s_tready is high. The source store is read
// or written at most once per item at a fixed stage, so loads and queries stay
// ordered without forwarding. A 32-deep result queue decouples the sides; s_tready
// drops only when words in flight plus words queued reach 32, so a stalled receiver
// stops the input before the queue overflows and the pipe never stalls internally.
// Reset: config returns to sizes 1, offsets 0, key 0xFF00FF, mode 0; the pipe and
// queue empty. Source store contents are undefined until loaded.
module color_key_tile_blitter_unit #(
	parameter int unsigned SRC_DEPTH = ckb_pkg::SRC_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// load_index, src_r, src_g, src_b, mask_r, mask_g, mask_b, dest_x, dest_y
	input  logic [87:0]                      s_tdata,
	// func
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// dest_index, out_r, out_g, out_b
	output logic [47:0]                      m_tdata,
	// write_enable
	output logic                             m_tuser,
	input  logic                             cfg_we,
	input  logic [ckb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ckb_pkg::CFG_W-1:0]        cfg_data
);

	localparam int unsigned SAW   = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
	localparam int unsigned CW    = ckb_pkg::COORD_W;
	localparam int unsigned DW    = ckb_pkg::DIM_W;
	localparam int unsigned OW    = ckb_pkg::OFS_W;
	localparam int unsigned PRD_W = CW + DW;
	localparam int unsigned CNT_W = $clog2(ckb_pkg::OUT_DEPTH + 1);
	localparam int unsigned IW    = $bits(ckb_pkg::item_t);

	// ---------------- configuration registers ----------------
	logic [DW-1:0]             dw_q, dh_q, sw_q, sh_q;
	logic signed [OW-1:0]      offx_q, offy_q;
	logic [ckb_pkg::PIX_W-1:0] key_q;
	logic [1:0]                mode_q;
	logic [DW-1:0]             cfg_dim;

	// sizes above the maximum clamp to it
	assign cfg_dim = (cfg_data[DW-1:0] > DW'(ckb_pkg::MAX_DIM)) ? DW'(ckb_pkg::MAX_DIM)
	                                                            : cfg_data[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q   <= DW'(1);
			dh_q   <= DW'(1);
			sw_q   <= DW'(1);
			sh_q   <= DW'(1);
			offx_q <= '0;
			offy_q <= '0;
			key_q  <= 24'hFF00FF;
			mode_q <= '0;
		end else if (cfg_we) begin
			unique case (ckb_pkg::cfg_reg_t'(cfg_index))
				ckb_pkg::CFG_DEST_WIDTH:  dw_q   <= cfg_dim;
				ckb_pkg::CFG_DEST_HEIGHT: dh_q   <= cfg_dim;
				ckb_pkg::CFG_SRC_WIDTH:   sw_q   <= cfg_dim;
				ckb_pkg::CFG_SRC_HEIGHT:  sh_q   <= cfg_dim;
				ckb_pkg::CFG_OFFSET_X:    offx_q <= cfg_data[OW-1:0];
				ckb_pkg::CFG_OFFSET_Y:    offy_q <= cfg_data[OW-1:0];
				ckb_pkg::CFG_KEY_COLOR:   key_q  <= cfg_data[ckb_pkg::PIX_W-1:0];
				ckb_pkg::CFG_MODE:        mode_q <= cfg_data[1:0];
			endcase
		end
	end

	// ---------------- credit: words in pipe plus queue ----------------
	logic             acc, pop;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] q_level;

	assign s_tready = (cnt_q < CNT_W'(ckb_pkg::OUT_DEPTH));
	assign acc      = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({acc, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// ---------------- s1: input register ----------------
	ckb_pkg::item_t           item_in, item_s1;
	logic                     vld_s1;
	logic [CW-1:0]            x_s1, y_s1;
	logic [ckb_pkg::PIX_W-1:0] mask_in;

	assign mask_in       = {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
	assign item_in.func  = s_tuser;
	assign item_in.li    = s_tdata[15:0];
	assign item_in.li_ok = (32'(s_tdata[15:0]) < 32'(SRC_DEPTH));
	assign item_in.pix   = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
	assign item_in.keyed = (mask_in == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_in;
		x_s1    <= s_tdata[75:64];
		y_s1    <= s_tdata[87:76];
	end

	// ---------------- tile modulo ----------------
	logic           m_vld;
	logic [CW-1:0]  m_x, m_y, m_rx, m_ry;
	logic [IW-1:0]  m_pl;
	ckb_pkg::item_t m_item;

	ckb_mod_pipe #(.PW(IW)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.in_x    (x_s1),
		.in_y    (y_s1),
		.in_pl   (item_s1),
		.div_x   (sw_q),
		.div_y   (sh_q),
		.out_vld (m_vld),
		.out_x   (m_x),
		.out_y   (m_y),
		.out_rx  (m_rx),
		.out_ry  (m_ry),
		.out_pl  (m_pl)
	);

	assign m_item = ckb_pkg::item_t'(m_pl);

	// ---------------- s2: source position and bounds ----------------
	logic signed [OW:0] sxp, syp;       // placed-mode position, may be negative
	logic               placed, dest_ok, src_ok_p, src_ok_t;
	logic [CW-1:0]      sx_sel, sy_sel;
	logic [DW-1:0]      srow_full, drow_full;

	assign placed   = mode_q[ckb_pkg::MODE_PLACED];
	assign sxp      = $signed({3'b000, m_x}) - $signed({offx_q[OW-1], offx_q});
	assign syp      = $signed({3'b000, m_y}) - $signed({offy_q[OW-1], offy_q});
	assign src_ok_p = !sxp[OW] && (sxp[OW-1:0] < OW'(sw_q))
	               && !syp[OW] && (syp[OW-1:0] < OW'(sh_q));
	assign src_ok_t = (sw_q != '0) && (sh_q != '0);
	assign dest_ok  = ({1'b0, m_x} < dw_q) && ({1'b0, m_y} < dh_q);
	assign sx_sel   = placed ? sxp[CW-1:0] : m_rx;
	assign sy_sel   = placed ? syp[CW-1:0] : m_ry;
	// rows are stored top first
	assign srow_full = DW'(sh_q - DW'(1) - {1'b0, sy_sel});
	assign drow_full = DW'(dh_q - DW'(1) - {1'b0, m_y});

	logic           vld_s2, ok_s2;
	ckb_pkg::item_t item_s2;
	logic [CW-1:0]  sx_s2, srow_s2, drow_s2, x_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= m_vld;
		end
	end

	always_ff @(posedge clk) begin
		item_s2 <= m_item;
		ok_s2   <= dest_ok && (placed ? src_ok_p : src_ok_t);
		sx_s2   <= sx_sel;
		srow_s2 <= srow_full[CW-1:0];
		drow_s2 <= drow_full[CW-1:0];
		x_s2    <= m_x;
	end

	// ---------------- s3: row products ----------------
	logic             vld_s3, ok_s3;
	ckb_pkg::item_t   item_s3;
	logic [CW-1:0]    sx_s3, x_s3;
	logic [PRD_W-1:0] sprod_s3, dprod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s3  <= item_s2;
		ok_s3    <= ok_s2;
		sx_s3    <= sx_s2;
		x_s3     <= x_s2;
		sprod_s3 <= PRD_W'(srow_s2) * PRD_W'(sw_q);
		dprod_s3 <= PRD_W'(drow_s2) * PRD_W'(dw_q);
	end

	// ---------------- s4: linear indexes ----------------
	logic                       vld_s4, ok_s4;
	ckb_pkg::item_t             item_s4;
	logic [PRD_W-1:0]           sidx_s4;
	logic [ckb_pkg::DIDX_W-1:0] didx_s4;
	logic [PRD_W-1:0]           dsum;

	assign dsum = dprod_s3 + PRD_W'(x_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		item_s4 <= item_s3;
		ok_s4   <= ok_s3;
		sidx_s4 <= sprod_s3 + PRD_W'(sx_s3);
		didx_s4 <= dsum[ckb_pkg::DIDX_W-1:0];
	end

	// ---------------- source store access ----------------
	// loads write and queries read at this one stage, so order is kept
	logic                       st_wr, st_rd;
	logic [ckb_pkg::PIX_W:0]    st_rdata;

	assign st_wr = vld_s4 && !item_s4.func && item_s4.li_ok;
	assign st_rd = vld_s4 && item_s4.func;

	ckb_src_store #(
		.DEPTH (SRC_DEPTH),
		.AW    (SAW),
		.DW    (ckb_pkg::PIX_W + 1)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr),
		.wr_addr (SAW'(item_s4.li)),
		.wr_data ({item_s4.keyed, item_s4.pix}),
		.rd_en   (st_rd),
		.rd_addr (SAW'(sidx_s4)),
		.rd_data (st_rdata)
	);

	// ---------------- s5: result ----------------
	logic                       vld_s5, func_s5, ok_s5;
	logic [ckb_pkg::DIDX_W-1:0] didx_s5;
	ckb_pkg::res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		func_s5 <= item_s4.func;
		ok_s5   <= ok_s4 && (32'(sidx_s4) < 32'(SRC_DEPTH));
		didx_s5 <= didx_s4;
	end

	always_comb begin
		res    = '0;
		res.we = func_s5 && ok_s5
		      && !(mode_q[ckb_pkg::MODE_KEY] && st_rdata[ckb_pkg::PIX_W]);
		if (res.we) begin
			res.didx = didx_s5;
			res.pix  = st_rdata[ckb_pkg::PIX_W-1:0];
		end
	end

	// ---------------- result queue ----------------
	ckb_pkg::res_t q_out;

	ckb_out_fifo #(
		.DEPTH (ckb_pkg::OUT_DEPTH),
		.W     ($bits(ckb_pkg::res_t))
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s5),
		.push_data (res),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_data  (q_out),
		.level     (q_level)
	);

	assign m_tuser = q_out.we;
	assign m_tdata = {q_out.pix[7:0], q_out.pix[15:8], q_out.pix[23:16], q_out.didx};

	// ---------------- checks ----------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ckb_pkg::OUT_DEPTH))
		else $error("credit count above queue depth");

	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= cnt_q)
		else $error("queued words exceed words in flight");

	a_accept_counts: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> cnt_q != '0)
		else $error("accepted word not counted");

	a_store_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_wr && st_rd))
		else $error("store read and write in one cycle");

endmodule
